// ===== rtl/grid_scan_brent_line_search_top_assert.svh =====
`ifndef GRID_SCAN_BRENT_LINE_SEARCH_TOP_ASSERT_SVH
`define GRID_SCAN_BRENT_LINE_SEARCH_TOP_ASSERT_SVH
// Same-cycle implication, sampled on clk, off while rst is high.
`define GSBL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off while rst is high.
`define GSBL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== rtl/gsbl_pkg.sv =====
package gsbl_pkg;

  localparam int VALUE_W             = 32;
  localparam int FRAC_W              = 24;
  localparam int CFG_W               = 31;
  localparam int ITER_W              = 6;
  localparam int MAX_SCAN_POINTS_DEF = 1024;

  typedef logic signed [VALUE_W-1:0] val_t;
  typedef logic signed [VALUE_W:0]   opd_t;
  typedef logic signed [VALUE_W+3:0] wide_t;
  typedef logic        [1:0]         kind_t;

  localparam val_t VMAX    = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam val_t VMIN    = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam val_t CGOLD_Q = 32'sd6408326;  // 0.381966 in Q8.24

  localparam kind_t KIND_PROBE = 2'd0;
  localparam kind_t KIND_DONE  = 2'd1;
  localparam kind_t KIND_FEW   = 2'd2;

  localparam logic [1:0] REG_SCAN_STEP = 2'd0;
  localparam logic [1:0] REG_TOLERANCE = 2'd1;
  localparam logic [1:0] REG_MAX_ITER  = 2'd2;

  typedef struct packed {
    logic op;
    val_t objective_value;
    logic last_sample;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    val_t              point;
    logic [ITER_W-1:0] iterations_used;
  } out_item_t;

  typedef struct packed {
    logic start;
    val_t num;
    val_t den;
  } div_req_t;

  typedef struct packed {
    logic done;
    val_t quo;
  } div_rsp_t;

  function automatic wide_t wx(input val_t v);
    return wide_t'(v);
  endfunction

  function automatic wide_t wabs(input wide_t v);
    return (v < 0) ? -v : v;
  endfunction

  // floor(v/2)
  function automatic wide_t whalf(input wide_t v);
    return v >>> 1;
  endfunction

  function automatic val_t sat_w(input wide_t v);
    if (v > wx(VMAX)) return VMAX;
    else if (v < wx(VMIN)) return VMIN;
    else return v[VALUE_W-1:0];
  endfunction

endpackage

// ===== rtl/gsbl_mul.sv =====
module gsbl_mul import gsbl_pkg::*; (
  input  logic clk,
  input  opd_t a,
  input  opd_t b,
  output val_t res
);

  localparam int SH_W = 2*VALUE_W - FRAC_W;
  localparam logic [SH_W-1:0] POS_LIM = SH_W'(VMAX);
  localparam logic [SH_W-1:0] NEG_LIM = POS_LIM + SH_W'(1);

  opd_t                   na, nb;
  logic [VALUE_W-1:0]     ua, ub;
  logic [2*VALUE_W-1:0]   prod;
  logic [SH_W-1:0]        sh;
  logic                   neg;
  val_t                   res_next;

  assign na   = -a;
  assign nb   = -b;
  assign ua   = a[VALUE_W] ? na[VALUE_W-1:0] : a[VALUE_W-1:0];
  assign ub   = b[VALUE_W] ? nb[VALUE_W-1:0] : b[VALUE_W-1:0];
  assign prod = ua * ub;
  assign sh   = prod[2*VALUE_W-1:FRAC_W];  // truncates toward zero on magnitude
  assign neg  = a[VALUE_W] ^ b[VALUE_W];

  always_comb begin
    if (neg) res_next = (sh > NEG_LIM) ? VMIN : -val_t'(sh[VALUE_W-1:0]);
    else     res_next = (sh > POS_LIM) ? VMAX : val_t'(sh[VALUE_W-1:0]);
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

// ===== rtl/gsbl_div.sv =====
module gsbl_div import gsbl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int NW  = VALUE_W + FRAC_W;
  localparam int CW  = $clog2(NW);
  localparam logic [NW-1:0] POS_LIM = NW'(VMAX);
  localparam logic [NW-1:0] NEG_LIM = POS_LIM + NW'(1);

  logic               busy, done, neg, zero, pnn;
  logic [CW-1:0]      cnt;
  logic [VALUE_W-1:0] rem, dq, up, uq;
  logic [NW-1:0]      nq;
  logic [VALUE_W:0]   trial, diff;
  logic               ge;
  val_t               nnum, nden;

  assign nnum  = -req.num;
  assign nden  = -req.den;
  assign up    = req.num[VALUE_W-1] ? nnum : req.num;
  assign uq    = req.den[VALUE_W-1] ? nden : req.den;
  assign trial = {rem, nq[NW-1]};
  assign diff  = trial - {1'b0, dq};
  assign ge    = trial >= {1'b0, dq};

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      rem  <= '0;
      nq   <= {up, {FRAC_W{1'b0}}};
      dq   <= uq;
      neg  <= req.num[VALUE_W-1] ^ req.den[VALUE_W-1];
      pnn  <= !req.num[VALUE_W-1];
      zero <= (uq == '0);
      cnt  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rem  <= ge ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
      nq   <= {nq[NW-2:0], ge};
      cnt  <= cnt + CW'(1);
      busy <= (cnt != CW'(NW-1));
      done <= (cnt == CW'(NW-1));
    end else begin
      done <= 1'b0;
    end
  end

  always_comb begin
    rsp.done = done;
    if (zero)     rsp.quo = pnn ? VMAX : VMIN;
    else if (neg) rsp.quo = (nq > NEG_LIM) ? VMIN : -val_t'(nq[VALUE_W-1:0]);
    else          rsp.quo = (nq > POS_LIM) ? VMAX : val_t'(nq[VALUE_W-1:0]);
  end

endmodule

// ===== rtl/grid_scan_brent_line_search_top.sv =====
// Grid sample: accepted in idle and decoded, then ready again; the last sample also computes the
// bracket (two passes of one small index multiplier) and its midpoint before the probe result.
// Probe value: a golden-section step, a parabolic fit that is tried and rejected, or a parabolic
// step (shared 32x32 multiplier, restoring divider) leads to the next probe result.
// One transaction in flight at a time; the output register holds one result.
// rst (synchronous) restores register defaults, returns to scanning, and clears counts.
module grid_scan_brent_line_search_top import gsbl_pkg::*; #(
  parameter int MAX_SCAN_POINTS = MAX_SCAN_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_addr,
  input  logic [CFG_W-1:0]  cfg_data
);

  `include "grid_scan_brent_line_search_top_assert.svh"

  localparam int CNT_W = $clog2(MAX_SCAN_POINTS + 1);
  localparam int BP_W  = CNT_W + CFG_W;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_BLO, S_BHI, S_MID,
    S_P0, S_P1, S_P2, S_P3,
    S_PA, S_PB, S_PC, S_PD, S_PE, S_PF, S_PG, S_PH, S_PI, S_PJ, S_PK,
    S_G0, S_G1, S_G2, S_FIN, S_EMIT
  } state_t;

  typedef enum logic [1:0] {PH_SCAN, PH_FIRST, PH_PROBE, PH_DONE} phase_t;

  state_t state;
  phase_t phase;

  // configuration
  logic [CFG_W-1:0]  scan_step, tolerance;
  logic [ITER_W-1:0] max_iterations;

  // scan bookkeeping
  logic [CNT_W-1:0] scan_count, best_scan_index, lo_idx, hi_idx;
  val_t             best_scan_value;

  // Brent state: bracket, x/w/v with values, steps d and e
  val_t bracket_low, bracket_high, x, w, v, fx, fw, fv, d, e, probe_point;
  logic [ITER_W-1:0] iteration;

  // per-iteration scratch
  val_t  tol1, xm, r, q, p, t1, t4, etemp;
  wide_t tol2, h3;

  in_item_t  item;
  out_item_t res;

  // shared units
  opd_t     mul_a, mul_b;
  val_t     mul_res;
  div_req_t div_req;
  div_rsp_t div_rsp;

  gsbl_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .res(mul_res));
  gsbl_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // ---- grid sample update (a new scan starts when not scanning) ----
  logic             clr, take, upd, few;
  logic [CNT_W-1:0] cnt0, bi0, cnt1, bi1, lo_n, hi_n;
  val_t             bv0, bv1, val;

  always_comb begin
    val  = item.objective_value;
    clr  = (phase != PH_SCAN);
    cnt0 = clr ? '0 : scan_count;
    bi0  = clr ? '0 : best_scan_index;
    bv0  = clr ? '0 : best_scan_value;
    take = (cnt0 < CNT_W'(MAX_SCAN_POINTS));
    upd  = take && ((cnt0 == '0) || (val > bv0));   // first maximum wins
    cnt1 = take ? cnt0 + CNT_W'(1) : cnt0;
    bi1  = upd ? cnt0 : bi0;
    bv1  = upd ? val : bv0;
    few  = (cnt1 < CNT_W'(2));
    if (bi1 == '0) begin
      lo_n = '0;
      hi_n = CNT_W'(1);
    end else if (bi1 == cnt1 - CNT_W'(1)) begin
      lo_n = cnt1 - CNT_W'(2);
      hi_n = cnt1 - CNT_W'(1);
    end else begin
      lo_n = bi1 - CNT_W'(1);
      hi_n = bi1 + CNT_W'(1);
    end
  end

  // grid point = index * scan_step, saturated
  logic [BP_W-1:0] bprod;
  val_t            bpoint;
  assign bprod  = (state == S_BLO ? lo_idx : hi_idx) * scan_step;
  assign bpoint = (bprod > BP_W'(VMAX)) ? VMAX : val_t'(bprod[VALUE_W-1:0]);

  // ---- probe result bookkeeping ----
  val_t  fu;
  wide_t tolr;
  logic  c_le0, c_ux, c_ux2, c_w, c_v;
  always_comb begin
    fu    = sat_w(-wx(val));
    tolr  = wide_t'(tolerance);
    c_le0 = (fu <= fx);
    c_ux  = (probe_point >= x);
    c_ux2 = (probe_point < x);
    c_w   = (fu <= fw) || (wabs(wx(w) - wx(x)) < tolr);
    c_v   = (fu <= fv) || (wabs(wx(v) - wx(x)) < tolr) || (wabs(wx(v) - wx(w)) < tolr);
  end

  // ---- step planning helpers ----
  val_t  tol1_n, xm_n, q2, p_e, p_f, q_f, e_g, d_k;
  wide_t tol2_n, u_k, u_f, h3_n;
  logic  p2_fin, p3_par, pj_gold, near;

  always_comb begin
    tol1_n  = sat_w(wx(mul_res) + wide_t'(1));
    tol2_n  = wx(tol1_n) <<< 1;
    xm_n    = val_t'(whalf(wx(bracket_low) + wx(bracket_high)));
    p2_fin  = wabs(wx(x) - wx(xm)) <= tol2 - whalf(wx(bracket_high) - wx(bracket_low));
    p3_par  = wabs(wx(e)) > wx(tol1);
    p_e     = sat_w(wx(t1) - wx(mul_res));
    q2      = sat_w((wx(q) - wx(r)) <<< 1);
    p_f     = (q > 0) ? sat_w(-wx(p)) : p;
    q_f     = sat_w(wabs(wx(q)));
    h3_n    = wabs(whalf(wx(mul_res)));
    pj_gold = (wabs(wx(p)) >= h3) || (p <= t4) || (p >= mul_res);
    u_k     = wx(x) + wx(div_rsp.quo);
    near    = (u_k - wx(bracket_low) < tol2) || (wx(bracket_high) - u_k < tol2);
    d_k     = near ? ((wx(xm) - wx(x) >= 0) ? tol1 : -tol1) : div_rsp.quo;
    e_g     = sat_w((x >= xm) ? wx(bracket_low) - wx(x) : wx(bracket_high) - wx(x));
    if (wabs(wx(d)) >= wx(tol1)) u_f = wx(x) + wx(d);
    else if (d >= 0)             u_f = wx(x) + wx(tol1);
    else                         u_f = wx(x) - wx(tol1);
  end

  // multiplier operand select; product is registered and ready in the next state
  always_comb begin
    mul_a = opd_t'(q);
    mul_b = opd_t'(etemp);
    case (state)
      S_P0: begin
        mul_a = opd_t'(tolerance);
        mul_b = opd_t'(wabs(wx(x)));
      end
      S_PA: begin
        mul_a = opd_t'(sat_w(wx(x) - wx(w)));
        mul_b = opd_t'(sat_w(wx(fx) - wx(fv)));
      end
      S_PB: begin
        mul_a = opd_t'(sat_w(wx(x) - wx(v)));
        mul_b = opd_t'(sat_w(wx(fx) - wx(fw)));
      end
      S_PC: begin
        mul_a = opd_t'(sat_w(wx(x) - wx(v)));
        mul_b = opd_t'(mul_res);
      end
      S_PD: begin
        mul_a = opd_t'(sat_w(wx(x) - wx(w)));
        mul_b = opd_t'(r);
      end
      S_PH: mul_b = opd_t'(sat_w(wx(bracket_low) - wx(x)));
      S_PI: mul_b = opd_t'(sat_w(wx(bracket_high) - wx(x)));
      S_G1: begin
        mul_a = opd_t'(CGOLD_Q);
        mul_b = opd_t'(e);
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start = (state == S_PJ) && !pj_gold;
    div_req.num   = p;
    div_req.den   = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      phase           <= PH_SCAN;
      out_valid       <= 1'b0;
      scan_step       <= CFG_W'(167772);
      tolerance       <= CFG_W'(16777);
      max_iterations  <= ITER_W'(20);
      scan_count      <= '0;
      best_scan_index <= '0;
      best_scan_value <= '0;
      iteration       <= '0;
    end else begin
      // output register: load from emit, clear when the result transaction is taken
      if (state == S_EMIT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_ready)                               out_valid <= 1'b0;

      if (cfg_valid) begin
        unique case (cfg_addr)
          REG_SCAN_STEP: scan_step      <= cfg_data;
          REG_TOLERANCE: tolerance      <= cfg_data;
          REG_MAX_ITER:  max_iterations <= cfg_data[ITER_W-1:0];
          default: ;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item  <= in_data;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          if (!item.op) begin
            phase <= PH_SCAN;
            if (item.last_sample && few) begin
              scan_count      <= '0;
              best_scan_index <= '0;
              best_scan_value <= '0;
              res             <= '{kind: KIND_FEW, point: '0, iterations_used: '0};
              state           <= S_EMIT;
            end else begin
              scan_count      <= cnt1;
              best_scan_index <= bi1;
              best_scan_value <= bv1;
              if (item.last_sample) begin
                lo_idx <= lo_n;
                hi_idx <= hi_n;
                state  <= S_BLO;
              end else begin
                state  <= S_IDLE;
              end
            end
          end else if (phase == PH_FIRST) begin
            fx    <= fu;
            fw    <= fu;
            fv    <= fu;
            state <= S_P0;
          end else if (phase == PH_PROBE) begin
            if (c_le0) begin
              if (c_ux) bracket_low <= x;
              else      bracket_high <= x;
              v  <= w;
              w  <= x;
              x  <= probe_point;
              fv <= fw;
              fw <= fx;
              fx <= fu;
            end else begin
              if (c_ux2) bracket_low <= probe_point;
              else       bracket_high <= probe_point;
              if (c_w) begin
                v  <= w;
                w  <= probe_point;
                fv <= fw;
                fw <= fu;
              end else if (c_v) begin
                v  <= probe_point;
                fv <= fu;
              end
            end
            if (iteration != {ITER_W{1'b1}}) iteration <= iteration + ITER_W'(1);
            state <= S_P0;
          end else begin
            state <= S_IDLE;  // stray probe value: dropped
          end
        end
        S_BLO: begin
          bracket_low <= bpoint;
          state       <= S_BHI;
        end
        S_BHI: begin
          bracket_high <= bpoint;
          state        <= S_MID;
        end
        S_MID: begin
          probe_point <= xm_n;
          x           <= xm_n;
          w           <= xm_n;
          v           <= xm_n;
          d           <= '0;
          e           <= '0;
          iteration   <= '0;
          phase       <= PH_FIRST;
          res         <= '{kind: KIND_PROBE, point: xm_n, iterations_used: '0};
          state       <= S_EMIT;
        end
        S_P0: begin
          if (iteration >= max_iterations) begin
            phase <= PH_DONE;
            res   <= '{kind: KIND_DONE, point: probe_point, iterations_used: iteration};
            state <= S_EMIT;
          end else begin
            state <= S_P1;
          end
        end
        S_P1: begin
          tol1  <= tol1_n;
          tol2  <= tol2_n;
          xm    <= xm_n;
          state <= S_P2;
        end
        S_P2: begin
          if (p2_fin) begin
            phase <= PH_DONE;
            res   <= '{kind: KIND_DONE, point: probe_point, iterations_used: iteration};
            state <= S_EMIT;
          end else begin
            state <= S_P3;
          end
        end
        S_P3: state <= p3_par ? S_PA : S_G0;
        S_PA: state <= S_PB;
        S_PB: begin
          r     <= mul_res;
          state <= S_PC;
        end
        S_PC: begin
          q     <= mul_res;
          state <= S_PD;
        end
        S_PD: begin
          t1    <= mul_res;
          state <= S_PE;
        end
        S_PE: begin
          p     <= p_e;
          q     <= q2;
          state <= S_PF;
        end
        S_PF: begin
          p     <= p_f;
          q     <= q_f;
          etemp <= e;
          e     <= d;
          state <= S_PG;
        end
        S_PG: state <= S_PH;
        S_PH: begin
          h3    <= h3_n;
          state <= S_PI;
        end
        S_PI: begin
          t4    <= mul_res;
          state <= S_PJ;
        end
        S_PJ: state <= pj_gold ? S_G0 : S_PK;
        S_PK: begin
          if (div_rsp.done) begin
            d     <= d_k;
            state <= S_FIN;
          end
        end
        S_G0: begin
          e     <= e_g;
          state <= S_G1;
        end
        S_G1: state <= S_G2;
        S_G2: begin
          d     <= mul_res;
          state <= S_FIN;
        end
        S_FIN: begin
          probe_point <= sat_w(u_f);
          phase       <= PH_PROBE;
          res         <= '{kind: KIND_PROBE, point: sat_w(u_f), iterations_used: iteration};
          state       <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // too-few-points results carry no point and no iteration count
  `GSBL_ASSERT_IMP(a_few_zero, out_valid && out_data.kind == KIND_FEW,
    out_data.point == '0 && out_data.iterations_used == '0, "few-points result not zeroed")
  // divider finishes only while the sequencer waits for it
  `GSBL_ASSERT_IMP(a_div_wait, div_rsp.done, state == S_PK, "divider done outside wait state")
  // from idle the only way forward is decode
  `GSBL_ASSERT_NXT(a_idle_next, state == S_IDLE,
    state == S_IDLE || state == S_DECODE, "bad exit from idle")

endmodule
